FILE: rtl/fwm_pkg.sv
`timescale 1ns / 1ps
package fwm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_WINDOW = 7;

  localparam int PIX_W    = 16;
  localparam int WEIGHT_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 3;
  localparam int RES_W    = 32;
  localparam int CELL_W   = PIX_W + 1;

  typedef enum logic [CFG_AW-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_SKIP_MISSING   = 3'd2,
    REG_SIZE_A         = 3'd3,
    REG_WEIGHT_A       = 3'd4,
    REG_SIZE_B         = 3'd5,
    REG_WEIGHT_B       = 3'd6,
    REG_DISTINCT_SIZES = 3'd7
  } reg_index_t;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd4096;

endpackage

FILE: rtl/focal_weighted_window_mean_core.sv
`timescale 1ns / 1ps
// focal weighted window mean over one raster layer, pixels in raster order
// input channel in_valid/in_ready carries func, pixel_value, pixel_missing;
// func 0 is a pixel, func 1 a drain tick that flushes one pending result
// result channel out_valid/out_ready carries result_value (Q20.12),
// result_missing and last_cell; one result per raster cell
// a pixel gives the result for the cell HALF rows and HALF columns behind it,
// drain ticks after the last pixel give the remaining results
// each item is worked on alone: each window cell is read from the line store
// (up to (2*HALF+1)^2 cells), then one shared bit-serial divider runs up to
// three times; items causing no result are taken without leaving idle
// the next item is taken while a result waits in the output register;
// a stalled receiver holds the block once the following result is ready
// configuration is written on cfg_we with cfg_addr and cfg_data; the user
// must write it only while idle, which the block does not enforce; no item
// is taken in a cycle with a register write; writing image_width or
// image_height restarts the frame; reset clears counters and registers to
// defaults; the line store is not cleared, only cells written in the current frame are ever read
module focal_weighted_window_mean_core #(
  parameter int MAX_WIDTH  = fwm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fwm_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = fwm_pkg::DEF_MAX_WINDOW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fwm_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [fwm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic signed [fwm_pkg::PIX_W-1:0] pixel_value,
  input  logic                        pixel_missing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [fwm_pkg::RES_W-1:0] result_value,
  output logic                        result_missing,
  output logic                        last_cell
);
  import fwm_pkg::*;

  localparam int HALF  = MAX_WINDOW / 2;
  localparam int RING  = (2 * HALF + 2) * MAX_WIDTH;
  localparam int AW    = $clog2(RING);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int RW    = $clog2(HALF + 1);
  localparam int OW    = RW + 2;
  localparam int NCELL = (2 * HALF + 1) * (2 * HALF + 1);
  localparam int CW    = $clog2(NCELL + 1);
  localparam int SW    = PIX_W + CW;
  localparam int MW    = SW + WEIGHT_W + 1;
  localparam int AC    = MW + 1;
  localparam int DVW   = (CW > 4) ? CW : 4;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_ACC  = 10'b0000000100,
    S_MUL  = 10'b0000001000,
    S_DS   = 10'b0000010000,
    S_DW   = 10'b0000100000,
    S_FS   = 10'b0001000000,
    S_FW   = 10'b0010000000,
    S_OUT  = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_t;

  state_t state;

  logic [XW-1:0]       w_reg;
  logic [YW-1:0]       h_reg;
  logic                skip_reg;
  logic [2:0]          size_a_reg, size_b_reg;
  logic [WEIGHT_W-1:0] weight_a_reg, weight_b_reg;
  logic [3:0]          dist_reg;

  logic [PW-1:0] in_idx, out_pos;
  logic [AW-1:0] wptr, optr, ptr, rowp;
  logic          input_done;
  logic [YW-1:0] out_row;
  logic [XW-1:0] out_col;

  logic signed [OW-1:0] di, dj;
  logic                 c_a, c_b, c_inb, c_last;
  logic signed [SW-1:0] sum_a, sum_b;
  logic [CW-1:0]        cnt_a, cnt_b;
  logic                 poison, tsel;
  logic signed [MW-1:0] prod;
  logic signed [AC-1:0] acc;

  logic [CELL_W-1:0] rdata;
  logic              div_busy, div_start;
  logic [AC-1:0]     div_num, div_quo;
  logic [DVW-1:0]    div_den;

  logic [PW-1:0] total, lat;
  logic          in_fire, out_free, last_out, last_in;
  logic [RW-1:0] ra, rb, rmax;
  logic [AW:0]   base_sum, base_off;
  logic [AW-1:0] base;
  logic [AW:0]   rowp_sum;
  logic [AW-1:0] rowp_next, ptr_inc;
  logic signed [OW-1:0] sra, srb, srm;
  logic signed [YW+1:0] ci;
  logic signed [XW+1:0] cj;
  logic          in_a, in_b, in_bnd;
  logic          px_ok;
  logic signed [SW-1:0] px_val;
  logic signed [SW-1:0] cur_sum;
  logic [CW-1:0]        cur_cnt;
  logic [WEIGHT_W-1:0]  cur_weight;
  logic [MW-1:0]        prod_mag;
  logic [AC-1:0]        acc_mag;
  logic [3:0]           dist_eff;
  logic signed [AC-1:0] term;
  logic signed [RES_W-1:0] sat_value;

  function automatic logic [RW-1:0] radius(input logic [2:0] size);
    logic [2:0] r;
    r = (size == 3'd0) ? 3'd0 : 3'((size - 3'd1) >> 1);
    if (32'(r) > HALF) begin
      return RW'(HALF);
    end
    return RW'(r);
  endfunction

  assign total    = PW'(w_reg * h_reg);
  assign lat      = PW'(HALF * w_reg + HALF);
  assign in_ready = state == S_IDLE && !cfg_we;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign last_out = out_pos == total - 1'b1;
  assign last_in  = in_idx == total - 1'b1;

  assign ra   = (size_a_reg == 3'd0) ? '0 : radius(size_a_reg);
  assign rb   = (size_b_reg == 3'd0) ? '0 : radius(size_b_reg);
  assign rmax = (ra > rb) ? ra : rb;
  assign sra  = $signed({2'b00, ra});
  assign srb  = $signed({2'b00, rb});
  assign srm  = $signed({2'b00, rmax});

  // ring address of the window's top left cell
  assign base_off = (AW+1)'(rmax) * (AW+1)'(w_reg) + (AW+1)'(rmax);
  assign base_sum = {1'b0, optr} + (AW+1)'(RING) - base_off;
  assign base     = (base_sum >= (AW+1)'(RING)) ? AW'(base_sum - (AW+1)'(RING))
                                               : AW'(base_sum);
  assign rowp_sum  = {1'b0, rowp} + (AW+1)'(w_reg);
  assign rowp_next = (rowp_sum >= (AW+1)'(RING)) ? AW'(rowp_sum - (AW+1)'(RING))
                                                : AW'(rowp_sum);
  assign ptr_inc   = (32'(ptr) == RING - 1) ? '0 : ptr + 1'b1;

  assign ci     = $signed({2'b00, out_row}) + (YW+2)'(di);
  assign cj     = $signed({2'b00, out_col}) + (XW+2)'(dj);
  assign in_bnd = ci >= 0 && ci < $signed({2'b00, h_reg})
               && cj >= 0 && cj < $signed({2'b00, w_reg});
  assign in_a   = size_a_reg != 3'd0 && di >= -sra && di <= sra && dj >= -sra && dj <= sra;
  assign in_b   = size_b_reg != 3'd0 && di >= -srb && di <= srb && dj >= -srb && dj <= srb;

  assign px_ok  = c_inb && !rdata[PIX_W];
  assign px_val = SW'($signed(rdata[PIX_W-1:0]));

  assign cur_sum    = tsel ? sum_b : sum_a;
  assign cur_cnt    = tsel ? cnt_b : cnt_a;
  assign cur_weight = tsel ? weight_b_reg : weight_a_reg;
  assign prod_mag   = prod[MW-1] ? MW'(-prod) : MW'(prod);
  assign acc_mag    = acc[AC-1] ? AC'(-acc) : AC'(acc);
  assign dist_eff   = dist_reg;

  always_comb begin
    div_start = 1'b0;
    div_num   = AC'(prod_mag) + AC'(cur_cnt >> 1);
    div_den   = DVW'(cur_cnt);
    case (state)
      S_DS: begin
        div_start = 1'b1;
      end
      S_FS: begin
        div_start = 1'b1;
        div_num   = acc_mag + AC'(dist_eff >> 1);
        div_den   = DVW'(dist_eff);
      end
      default: begin
      end
    endcase
  end

  assign term = prod[MW-1] ? -$signed(div_quo) : $signed(div_quo);

  always_comb begin
    if (acc[AC-1]) begin
      sat_value = (div_quo > AC'(33'h080000000)) ? 32'sh80000000
                                                : RES_W'(-$signed(div_quo));
    end else begin
      sat_value = (div_quo > AC'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : RES_W'(div_quo);
    end
  end

  fwm_ram #(
    .WIDTH(CELL_W),
    .DEPTH(RING)
  ) u_line_store (
    .clk  (clk),
    .we   (in_fire && func == FUNC_PIXEL && !input_done),
    .waddr(wptr),
    .wdata({pixel_missing, pixel_value}),
    .raddr(ptr),
    .rdata(rdata)
  );

  fwm_div #(
    .NW(AC),
    .DW(DVW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      w_reg        <= XW'(1);
      h_reg        <= YW'(1);
      skip_reg     <= 1'b1;
      size_a_reg   <= '0;
      size_b_reg   <= '0;
      weight_a_reg <= WEIGHT_RESET;
      weight_b_reg <= WEIGHT_RESET;
      dist_reg     <= 4'd1;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_IMAGE_WIDTH: begin
          if (cfg_data[10:0] == '0) begin
            w_reg <= XW'(1);
          end else if (32'(cfg_data[10:0]) > MAX_WIDTH) begin
            w_reg <= XW'(MAX_WIDTH);
          end else begin
            w_reg <= XW'(cfg_data[10:0]);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data[10:0] == '0) begin
            h_reg <= YW'(1);
          end else if (32'(cfg_data[10:0]) > MAX_HEIGHT) begin
            h_reg <= YW'(MAX_HEIGHT);
          end else begin
            h_reg <= YW'(cfg_data[10:0]);
          end
        end
        REG_SKIP_MISSING:   skip_reg     <= cfg_data[0];
        REG_SIZE_A:         size_a_reg   <= cfg_data[2:0];
        REG_WEIGHT_A:       weight_a_reg <= cfg_data;
        REG_SIZE_B:         size_b_reg   <= cfg_data[2:0];
        REG_WEIGHT_B:       weight_b_reg <= cfg_data;
        REG_DISTINCT_SIZES: dist_reg     <= (cfg_data[3:0] == '0) ? 4'd1 : cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_idx     <= '0;
      wptr       <= '0;
      input_done <= 1'b0;
      out_pos    <= '0;
      optr       <= '0;
      out_row    <= '0;
      out_col    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (func == FUNC_DRAIN) begin
              if (input_done) begin
                state <= S_RD;
              end
            end else if (!input_done) begin
              if (last_in) begin
                in_idx     <= '0;
                wptr       <= '0;
                input_done <= 1'b1;
              end else begin
                in_idx <= in_idx + 1'b1;
                wptr   <= (32'(wptr) == RING - 1) ? '0 : wptr + 1'b1;
              end
              if (in_idx >= lat) begin
                state <= S_RD;
              end
            end
          end
        end
        S_RD:  state <= S_ACC;
        S_ACC: state <= c_last ? S_MUL : S_RD;
        S_MUL: begin
          if (poison) begin
            state <= S_OUT;
          end else if (cur_cnt != '0) begin
            state <= S_DS;
          end else if (tsel) begin
            state <= S_FS;
          end
        end
        S_DS: state <= S_DW;
        S_DW: begin
          if (!div_busy) begin
            state <= tsel ? S_FS : S_MUL;
          end
        end
        S_FS: state <= S_FW;
        S_FW: begin
          if (!div_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state     <= S_IDLE;
            if (last_out) begin
              out_pos    <= '0;
              optr       <= '0;
              out_row    <= '0;
              out_col    <= '0;
              in_idx     <= '0;
              wptr       <= '0;
              input_done <= 1'b0;
            end else begin
              out_pos <= out_pos + 1'b1;
              optr    <= (32'(optr) == RING - 1) ? '0 : optr + 1'b1;
              if (out_col == w_reg - 1'b1) begin
                out_col <= '0;
                out_row <= out_row + 1'b1;
              end else begin
                out_col <= out_col + 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we && (cfg_addr == REG_IMAGE_WIDTH || cfg_addr == REG_IMAGE_HEIGHT)) begin
        in_idx     <= '0;
        wptr       <= '0;
        input_done <= 1'b0;
        out_pos    <= '0;
        optr       <= '0;
        out_row    <= '0;
        out_col    <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        di     <= -srm;
        dj     <= -srm;
        ptr    <= base;
        rowp   <= base;
        sum_a  <= '0;
        sum_b  <= '0;
        cnt_a  <= '0;
        cnt_b  <= '0;
        poison <= 1'b0;
        tsel   <= 1'b0;
        acc    <= '0;
      end
      S_RD: begin
        c_a    <= in_a;
        c_b    <= in_b;
        c_inb  <= in_bnd;
        c_last <= di == srm && dj == srm;
        if (dj == srm) begin
          dj   <= -srm;
          di   <= di + 1'b1;
          rowp <= rowp_next;
          ptr  <= rowp_next;
        end else begin
          dj  <= dj + 1'b1;
          ptr <= ptr_inc;
        end
      end
      S_ACC: begin
        if (c_a) begin
          if (px_ok) begin
            sum_a <= sum_a + px_val;
            cnt_a <= cnt_a + 1'b1;
          end else if (!skip_reg) begin
            poison <= 1'b1;
          end
        end
        if (c_b) begin
          if (px_ok) begin
            sum_b <= sum_b + px_val;
            cnt_b <= cnt_b + 1'b1;
          end else if (!skip_reg) begin
            poison <= 1'b1;
          end
        end
      end
      S_MUL: begin
        prod <= MW'(cur_sum * $signed({1'b0, cur_weight}));
        if (!poison && cur_cnt == '0) begin
          tsel <= 1'b1;
        end
      end
      S_DW: begin
        if (!div_busy) begin
          acc  <= acc + term;
          tsel <= 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          result_value   <= poison ? '0 : sat_value;
          result_missing <= poison;
          last_cell      <= last_out;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    !(div_busy && (state == S_IDLE || state == S_OUT)))
    else $error("divider running outside arithmetic");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free && last_out && !cfg_we) |=>
    (out_pos == '0 && in_idx == '0 && !input_done))
    else $error("frame counters not restarted after last cell");
`endif

endmodule

FILE: rtl/fwm_ram.sv
`timescale 1ns / 1ps
module fwm_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fwm_div.sv
`timescale 1ns / 1ps
module fwm_div #(
  parameter int NW = 40,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);

  localparam int KW = $clog2(NW + 1);

  logic [KW-1:0] steps;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic          fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign busy  = steps != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= KW'(NW);
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule
